/* rtl/bfq_pkg.sv */
// Shared types and constants for the bounded FIFO with membership query.
// No dependencies; imported by the top level.
package bfq_pkg;

    localparam int VALUE_W             = 32;
    localparam int COUNT_FIELD_W       = 5;
    localparam int FUNC_W              = 2;
    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam logic [COUNT_FIELD_W-1:0] CAP_RESET = 5'd16;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] item_value;
    } cmd_item_t;

    typedef struct packed {
        logic                      success;
        logic signed [VALUE_W-1:0] popped_value;
        logic [COUNT_FIELD_W-1:0]  entry_count;
        logic                      is_full;
    } rsp_item_t;

endpackage

/* rtl/bfq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies; used for the queue entry store.
module bfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bounded_fifo_with_membership_query.sv */
// Bounded FIFO of signed 32-bit values with a membership query; top level.
// Depends on bfq_pkg (types, op codes) and bfq_ram (entry store).
//
// A ring of QUEUE_DEPTH entries held in one RAM, with head, tail and count
// registers and a 5-bit capacity register (reset 16; the effective capacity
// is the smaller of it and QUEUE_DEPTH). Each command transfer selects push,
// pop or query and yields exactly one response transfer carrying success,
// the popped value (zero unless a pop succeeded), the count after the
// operation and a full flag. The block takes one command at a time:
// cmd_ready is high only while the sequencer is idle. Push and refused
// operations go straight from idle to the finish step, which loads the
// response register; pop passes through a pop step first, which waits for
// the registered RAM read. A query walks the stored entries from the head
// through the single RAM read port and one shared 32-bit equality compare,
// one entry per cycle, and stops at the first hit, having read from one
// entry up to all stored entries; on an empty queue it goes straight to
// the finish step and issues no read. A finished response waits in
// the output register until taken; the next command can be accepted while
// it waits, and its own response is held until the output register frees.
// Capacity writes are taken at any cycle that cfg_we is high; change it
// only while no command is in flight.
module bounded_fifo_with_membership_query #(
    parameter int QUEUE_DEPTH = bfq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_ready,
    input  bfq_pkg::cmd_item_t                   cmd,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output bfq_pkg::rsp_item_t                   rsp,
    input  logic                                 cfg_we,
    input  logic [bfq_pkg::COUNT_FIELD_W-1:0]    cfg_wdata
);

    import bfq_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    // Common width for count / capacity compares.
    localparam int EXT_W = (CNT_W > COUNT_FIELD_W) ? CNT_W : COUNT_FIELD_W;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(QUEUE_DEPTH);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_POP    = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [PTR_W-1:0]         head_reg, head_next;
    logic [PTR_W-1:0]         tail_reg, tail_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [COUNT_FIELD_W-1:0] cap_reg;
    logic [PTR_W-1:0]         scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0]         scan_left_reg, scan_left_next;
    logic [VALUE_W-1:0]       value_reg, value_next;
    logic                     pend_success_reg, pend_success_next;
    logic [VALUE_W-1:0]       pend_popped_reg, pend_popped_next;
    rsp_item_t                rsp_reg, rsp_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    logic                     ram_we;
    logic                     ram_re;
    logic [PTR_W-1:0]         ram_raddr;
    logic [VALUE_W-1:0]       ram_rdata;

    logic [EXT_W-1:0]         count_ext;
    logic [EXT_W-1:0]         cap_ext;
    logic [EXT_W-1:0]         cap_eff;
    logic                     push_ok;
    logic                     full_now;
    logic                     hit;
    logic                     cmd_fire;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    bfq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (QUEUE_DEPTH),
        .AW    (PTR_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (value_next),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Effective capacity is the smaller of the register and the ring depth.
    assign count_ext = EXT_W'(count_reg);
    assign cap_ext   = EXT_W'(cap_reg);
    assign cap_eff   = (cap_ext > DEPTH_EXT) ? DEPTH_EXT : cap_ext;
    assign push_ok   = (count_ext < cap_eff);
    assign full_now  = (count_ext >= cap_eff);

    // The one shared compare unit: last entry read against the search value.
    assign hit = (ram_rdata == value_reg);

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        scan_ptr_next     = scan_ptr_reg;
        scan_left_next    = scan_left_reg;
        value_next        = value_reg;
        pend_success_next = pend_success_reg;
        pend_popped_next  = pend_popped_reg;
        rsp_next          = rsp_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp_ready;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        ram_raddr         = head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    value_next        = cmd.item_value;
                    pend_success_next = 1'b0;
                    pend_popped_next  = '0;
                    state_next        = ST_FINISH;
                    case (cmd.func)
                        FUNC_PUSH:
                        begin
                            if (push_ok)
                            begin
                                ram_we            = 1'b1;
                                tail_next         = next_slot(tail_reg);
                                count_next        = count_reg + 1'b1;
                                pend_success_next = 1'b1;
                            end
                        end
                        FUNC_POP:
                        begin
                            // Read the head now; data lands next cycle.
                            if (count_reg != '0)
                            begin
                                ram_re     = 1'b1;
                                head_next  = next_slot(head_reg);
                                count_next = count_reg - 1'b1;
                                state_next = ST_POP;
                            end
                        end
                        FUNC_QUERY:
                        begin
                            // Issue the first read at the head, then walk.
                            if (count_reg != '0)
                            begin
                                ram_re         = 1'b1;
                                scan_ptr_next  = next_slot(head_reg);
                                scan_left_next = count_reg - 1'b1;
                                state_next     = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            // Unused code: no operation, report state only.
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                pend_success_next = 1'b1;
                pend_popped_next  = ram_rdata;
                state_next        = ST_FINISH;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    pend_success_next = 1'b1;
                    state_next        = ST_FINISH;
                end
                else if (scan_left_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    // Advance to the next stored entry.
                    ram_re         = 1'b1;
                    ram_raddr      = scan_ptr_reg;
                    scan_ptr_next  = next_slot(scan_ptr_reg);
                    scan_left_next = scan_left_reg - 1'b1;
                end
            end
            ST_FINISH:
            begin
                // Hold until the output register is free or being drained.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.success      = pend_success_reg;
                    rsp_next.popped_value = pend_popped_reg;
                    rsp_next.entry_count  = count_ext[COUNT_FIELD_W-1:0];
                    rsp_next.is_full      = full_now;
                    rsp_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_ptr_reg     <= scan_ptr_next;
        scan_left_reg    <= scan_left_next;
        value_reg        <= value_next;
        pend_success_reg <= pend_success_next;
        pend_popped_reg  <= pend_popped_next;
        rsp_reg          <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A response only appears out of the finish step.
    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("response raised outside finish step");

    // The ring never holds more than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // An accepted push below capacity adds exactly one entry at the tail.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.func == FUNC_PUSH && push_ok)
        |=> (count_reg == $past(count_reg) + 1'b1)
            && (tail_reg == next_slot($past(tail_reg))))
        else $error("push did not advance tail and count");

    // The walk never issues more reads than entries stored.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_left_reg < count_reg))
        else $error("query walk overran stored entries");

    // Pop leaves head and count changed only when the queue was non-empty.
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.func == FUNC_POP && count_reg == '0)
        |=> $stable(head_reg) && (count_reg == '0))
        else $error("pop on empty queue changed state");

endmodule

/* sim/tb_bounded_fifo_with_membership_query.sv */
// Self-checking testbench for bounded_fifo_with_membership_query: directed and random
// push/pop/query traffic with random stalls, checked against an in-bench queue model.
// Depends on rtl/bfq_pkg.sv and rtl/bounded_fifo_with_membership_query.sv.
module tb_bounded_fifo_with_membership_query;
    timeunit 1ns;
    timeprecision 1ps;

    import bfq_pkg::*;

    localparam int DEPTH           = DEFAULT_QUEUE_DEPTH;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int MAX_PRINTED     = 40;
    localparam int RANDOM_ROUNDS   = 12;
    localparam int ROUND_ITEMS     = 110;
    localparam int DRAIN_CYCLES    = 4;
    localparam int TAIL_CYCLES     = 20;

    // The block treats the fourth func code as a no-op.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Traffic mixes for the random rounds.
    localparam int MIX_FILL     = 0;
    localparam int MIX_DRAIN    = 1;
    localparam int MIX_BALANCED = 2;

    logic                         clk;
    logic                         rst_n     = 1'b0;
    logic                         cmd_valid = 1'b0;
    logic                         cmd_ready;
    cmd_item_t                    cmd       = '0;
    logic                         rsp_valid;
    logic                         rsp_ready = 1'b0;
    rsp_item_t                    rsp;
    logic                         cfg_we    = 1'b0;
    logic [COUNT_FIELD_W-1:0]     cfg_wdata = CAP_RESET;

    // Queue model: ring of stored values plus pointers, count and capacity register.
    logic signed [VALUE_W-1:0]    model_values [DEPTH];
    int                           model_head     = 0;
    int                           model_tail     = 0;
    int                           model_count    = 0;
    int                           model_capacity = int'(CAP_RESET);

    // Responses predicted at each command transfer, oldest first.
    rsp_item_t                    pending_rsps [$];

    int                           error_count     = 0;
    int                           cmd_transfers   = 0;
    int                           refused_pushes  = 0;
    int                           query_hits      = 0;
    int                           capacity_writes = 0;
    int                           full_reports    = 0;

    // When set, the sender runs back to back and the receiver never stalls.
    bit                           back_to_back    = 1'b0;

    bounded_fifo_with_membership_query #(
        .QUEUE_DEPTH (DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Apply one command to the queue model and return the response it must produce.
    function automatic rsp_item_t predict_queue_rsp(cmd_item_t c);
        rsp_item_t r;
        int        cap;
        int        slot;
        cap  = (model_capacity > DEPTH) ? DEPTH : model_capacity;
        r    = '0;
        slot = model_head;
        case (c.func)
            FUNC_PUSH:
            begin
                if (model_count < cap)
                begin
                    model_values[model_tail] = c.item_value;
                    model_tail  = (model_tail + 1) % DEPTH;
                    model_count = model_count + 1;
                    r.success   = 1'b1;
                end
                else
                begin
                    refused_pushes++;
                end
            end
            FUNC_POP:
            begin
                if (model_count != 0)
                begin
                    r.popped_value = model_values[model_head];
                    model_head  = (model_head + 1) % DEPTH;
                    model_count = model_count - 1;
                    r.success   = 1'b1;
                end
            end
            FUNC_QUERY:
            begin
                // Walk only the stored entries, oldest first; the first match sets success.
                for (int k = 0; k < model_count; k++)
                begin
                    if (!r.success && model_values[slot] == c.item_value)
                        r.success = 1'b1;
                    slot = (slot + 1) % DEPTH;
                end
                if (r.success)
                    query_hits++;
            end
            default:
            begin
            end
        endcase
        r.entry_count = model_count[COUNT_FIELD_W-1:0];
        r.is_full     = (model_count >= cap);
        return r;
    endfunction

    // Idle length for either side: mostly zero or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (back_to_back || roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Push values: small clustered values so queries hit, extremes, and full-range noise.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int roll;
        int small_val;
        roll      = $urandom_range(0, 99);
        small_val = $urandom_range(0, 9);
        if (roll < 45)
            return small_val - 5;
        else if (roll < 55)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        else
            return $urandom;
    endfunction

    // Query values: mostly a value that is currently stored, otherwise a push-style value that may hit or miss.
    function automatic logic signed [VALUE_W-1:0] pick_query_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (model_count > 0 && roll < 55)
            return model_values[(model_head + $urandom_range(0, model_count - 1)) % DEPTH];
        else
            return pick_value();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTED)
            $display("%0t ns: MISMATCH %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Drive one command and hold it until the transfer; predict its response there.
    // Called at the edge of the previous transfer, so valid stays high when there is
    // no gap and only the payload changes.
    task automatic send_cmd(input logic [FUNC_W-1:0] op, input logic signed [VALUE_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= '{func: op, item_value: value};
        do
            @(posedge clk);
        while (!cmd_ready);
        pending_rsps.push_back(predict_queue_rsp(cmd));
        cmd_transfers++;
    endtask

    // Drop valid and hold off until every predicted response has been taken.
    task automatic wait_for_results();
        cmd_valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Capacity writes only go in while the block is idle.
    task automatic set_capacity(input logic [COUNT_FIELD_W-1:0] value);
        wait_for_results();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_capacity = int'(value);
        capacity_writes++;
        @(posedge clk);
    endtask

    // Pop and query on the empty queue after reset, plus the unused func code.
    task automatic test_empty_queue();
        send_cmd(FUNC_POP, $urandom);
        send_cmd(FUNC_QUERY, 32'sd0);
        send_cmd(FUNC_UNUSED, $urandom);
    endtask

    // Extreme values go through the store intact and are found by a query.
    task automatic test_value_extremes();
        send_cmd(FUNC_PUSH, 32'sh8000_0000);
        send_cmd(FUNC_PUSH, 32'sh7FFF_FFFF);
        send_cmd(FUNC_PUSH, -32'sd1);
        send_cmd(FUNC_PUSH, 32'sd0);
        send_cmd(FUNC_QUERY, 32'sh8000_0000);
        send_cmd(FUNC_QUERY, 32'sd1);
        repeat (4) send_cmd(FUNC_POP, $urandom);
    endtask

    // Lower the capacity under the current count: pushes refused, full set, pops still work.
    task automatic test_capacity_below_count();
        set_capacity(5'd16);
        send_cmd(FUNC_PUSH, 32'sd11);
        send_cmd(FUNC_PUSH, 32'sd22);
        send_cmd(FUNC_PUSH, 32'sd33);
        set_capacity(5'd2);
        send_cmd(FUNC_PUSH, 32'sd44);
        send_cmd(FUNC_QUERY, 32'sd33);
        send_cmd(FUNC_POP, $urandom);
    endtask

    // Zero capacity: every push refused and full reads high, even when empty.
    task automatic test_zero_capacity();
        set_capacity(5'd0);
        send_cmd(FUNC_PUSH, 32'sd55);
        send_cmd(FUNC_POP, $urandom);
        send_cmd(FUNC_POP, $urandom);
    endtask

    // One random round under a fixed capacity. Halfway through, the sender holds
    // off until every response is back, so the block also restarts from idle.
    task automatic test_random_round(input int mix, input int items);
        int roll;
        int push_cut;
        int pop_cut;
        int query_cut;
        case (mix)
            MIX_FILL:     begin push_cut = 65; pop_cut = 85; query_cut = 98; end
            MIX_DRAIN:    begin push_cut = 25; pop_cut = 80; query_cut = 98; end
            MIX_BALANCED: begin push_cut = 40; pop_cut = 70; query_cut = 98; end
            default:      begin push_cut = 40; pop_cut = 70; query_cut = 98; end
        endcase
        for (int i = 0; i < items; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < push_cut)
                send_cmd(FUNC_PUSH, pick_value());
            else if (roll < pop_cut)
                send_cmd(FUNC_POP, $urandom);
            else if (roll < query_cut)
                send_cmd(FUNC_QUERY, pick_query_value());
            else
                send_cmd(FUNC_UNUSED, $urandom);
            if (i == items / 2)
                wait_for_results();
        end
    endtask

    task automatic test_random_traffic();
        logic [COUNT_FIELD_W-1:0] caps [RANDOM_ROUNDS];
        caps = '{5'd16, 5'd31, 5'd1, 5'd8, 5'd0, 5'd16, 5'd17, 5'd3, 5'd12, 5'd16,
                 5'd0, 5'd0};
        // Last two settings are random: one from 0 to 16, one anywhere in the register's range.
        caps[RANDOM_ROUNDS-2] = COUNT_FIELD_W'($urandom_range(0, 16));
        caps[RANDOM_ROUNDS-1] = COUNT_FIELD_W'($urandom_range(0, 31));
        for (int r = 0; r < RANDOM_ROUNDS; r++)
        begin
            set_capacity(caps[r]);
            back_to_back = (r % 4 == 3);
            test_random_round(r % 3, ROUND_ITEMS);
        end
        back_to_back = 1'b0;
    endtask

    // Receiver: unless running back to back, stall for random stretches, then accept for a run of cycles.
    initial
    begin : rsp_side
        int stall;
        int run;
        @(posedge rst_n);
        forever
        begin
            if (back_to_back)
            begin
                rsp_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                stall = pick_gap();
                run   = $urandom_range(1, 8);
                if (stall > 0)
                begin
                    rsp_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                rsp_ready <= 1'b1;
                repeat (run) @(posedge clk);
            end
        end
    end

    // Compare each response transfer, field by field, with the oldest prediction.
    always @(posedge clk)
    begin : check_rsp
        rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsps.size() == 0)
            begin
                report_mismatch("response with no command pending",
                                32'(rsp.entry_count), '0);
            end
            else
            begin
                want = pending_rsps.pop_front();
                if (rsp.success !== want.success)
                    report_mismatch("success", 32'(rsp.success), 32'(want.success));
                if (rsp.popped_value !== want.popped_value)
                    report_mismatch("popped_value", rsp.popped_value, want.popped_value);
                if (rsp.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(rsp.entry_count),
                                    32'(want.entry_count));
                if (rsp.is_full !== want.is_full)
                    report_mismatch("is_full", 32'(rsp.is_full), 32'(want.is_full));
                if (rsp.is_full === 1'b1)
                    full_reports++;
            end
        end
    end

    // End the run when neither channel has moved a transfer for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: timeout, %0d cycles without a transfer, %0d responses pending",
                 $time, quiet, pending_rsps.size());
        $display("tb_bounded_fifo_with_membership_query NOT OK");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset capacity is exercised first, before any register write.
        test_empty_queue();
        test_value_extremes();
        test_capacity_below_count();
        test_zero_capacity();
        test_random_traffic();

        // Hold until the last response is back, then let the block settle.
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_rsps.size() != 0)
            report_mismatch("responses never delivered", pending_rsps.size(), '0);

        $display("Covered %0d command transfers over %0d capacity writes (0, 16 and above).",
                 cmd_transfers, capacity_writes);
        $display("Pushes refused: %0d, query hits: %0d, full flags seen: %0d, mismatches: %0d.",
                 refused_pushes, query_hits, full_reports, error_count);
        if (error_count == 0)
            $display("tb_bounded_fifo_with_membership_query OK");
        else
            $display("tb_bounded_fifo_with_membership_query NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
rtl/bfq_pkg.sv
rtl/bfq_ram.sv
rtl/bounded_fifo_with_membership_query.sv
sim/tb_bounded_fifo_with_membership_query.sv
